// ----- sv/tcd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, constants and the seven-segment decode for the turn counter.
// ----------------------------------------------------------------------------
package tcd_pkg;

	localparam int unsigned COUNT_W   = 14;
	localparam int unsigned DIGITS    = 4;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned POS_W     = 2;
	localparam int unsigned SEG_W     = 7;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT      = 14'd9999;
	localparam logic [COUNT_W-1:0] PRESET_LOW_INIT  = 14'd100;
	localparam logic [COUNT_W-1:0] PRESET_HIGH_INIT = 14'd160;

	// configuration register indexes
	localparam logic CFG_PRESET_LOW  = 1'b0;
	localparam logic CFG_PRESET_HIGH = 1'b1;

	typedef enum logic [1:0] {
		IND_BELOW = 2'd0,
		IND_EQUAL = 2'd1,
		IND_ABOVE = 2'd2
	} indication_t;

	typedef struct packed {
		logic sensor_first;
		logic sensor_second;
		logic sensor_third;
		logic store_button;
		logic preset_low_button;
		logic clear_button;
		logic preset_high_button;
	} item_t;

	typedef struct packed {
		indication_t        indication;
		logic [POS_W-1:0]   digit_position;
		logic [SEG_W-1:0]   segment_pattern;
		logic [COUNT_W-1:0] turn_count;
	} result_t;

	// turn events found by the direction detector in one tick
	typedef struct packed {
		logic up;
		logic down;
	} turn_t;

	// bit0 = segment a ... bit6 = segment g; codes above nine show blank
	function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] seg;
		unique case (d)
			4'd0:    seg = 7'h3F;
			4'd1:    seg = 7'h06;
			4'd2:    seg = 7'h5B;
			4'd3:    seg = 7'h4F;
			4'd4:    seg = 7'h66;
			4'd5:    seg = 7'h6D;
			4'd6:    seg = 7'h7D;
			4'd7:    seg = 7'h07;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h6F;
			default: seg = '0;
		endcase
		return seg;
	endfunction

endpackage

// ----- sv/tcd_phase.sv -----
// ----------------------------------------------------------------------------
// tcd_phase
// Five-phase direction detector over the three position contacts.
// ----------------------------------------------------------------------------
module tcd_phase (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  tcd_pkg::item_t item,
	output tcd_pkg::turn_t turn
);

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_FIRST        = 3'd1,
		PH_FIRST_SECOND = 3'd2,
		PH_THIRD        = 3'd4,
		PH_THIRD_SECOND = 3'd5
	} phase_t;

	phase_t phase_q;
	phase_t ph;
	logic   s1, s2, s3;

	assign s1 = item.sensor_first;
	assign s2 = item.sensor_second;
	assign s3 = item.sensor_third;

	// each rule sees the phase left by the rules above it
	always_comb begin
		ph        = phase_q;
		turn.up   = 1'b0;
		turn.down = 1'b0;
		if (ph == PH_IDLE && s1) ph = PH_FIRST;
		if (ph == PH_FIRST && s3) ph = PH_THIRD;
		if (ph == PH_FIRST && s2) ph = PH_FIRST_SECOND;
		if (ph == PH_FIRST_SECOND && s3) begin
			ph      = PH_FIRST;
			turn.up = 1'b1;
		end
		if (ph == PH_FIRST_SECOND && s1) ph = PH_FIRST;
		if (ph == PH_IDLE && s3) ph = PH_THIRD;
		if (ph == PH_THIRD && s1) ph = PH_FIRST;
		if (ph == PH_FIRST && s3) ph = PH_THIRD;
		if (ph == PH_THIRD && s2) ph = PH_THIRD_SECOND;
		if (ph == PH_THIRD_SECOND && s1) begin
			ph        = PH_FIRST;
			turn.down = 1'b1;
		end
		if (ph == PH_THIRD_SECOND && s3) ph = PH_THIRD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (adv) begin
			phase_q <= ph;
		end
	end

endmodule

// ----- sv/tcd_count.sv -----
// ----------------------------------------------------------------------------
// tcd_count
// Turn count in binary and decimal digits, target, compare and digit scan.
// ----------------------------------------------------------------------------
module tcd_count (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  tcd_pkg::item_t                  item,
	input  tcd_pkg::turn_t                  turn,
	input  logic [tcd_pkg::COUNT_W-1:0]     preset_low,
	input  logic [tcd_pkg::COUNT_W-1:0]     preset_high,
	output tcd_pkg::result_t                result
);

	logic [tcd_pkg::COUNT_W-1:0] cnt_q, target_q;
	logic [tcd_pkg::DIGITS-1:0][tcd_pkg::DIGIT_W-1:0] bcd_q;
	logic [tcd_pkg::POS_W-1:0]   scan_q;

	logic [tcd_pkg::COUNT_W-1:0] cnt_mid, cnt_clr, cnt_nxt, target_nxt;
	logic [tcd_pkg::DIGITS-1:0][tcd_pkg::DIGIT_W-1:0] bcd_inc, bcd_dec, bcd_mid, bcd_nxt;
	logic                        carry, borrow, at_zero;
	tcd_pkg::indication_t        ind;

	assign at_zero = (cnt_q == '0);

	// decimal digits follow the binary count step for step
	always_comb begin
		carry  = 1'b1;
		borrow = 1'b1;
		for (int i = 0; i < tcd_pkg::DIGITS; i++) begin
			bcd_inc[i] = bcd_q[i];
			bcd_dec[i] = bcd_q[i];
			if (carry) begin
				if (bcd_q[i] == 4'd9) begin
					bcd_inc[i] = '0;
				end else begin
					bcd_inc[i] = bcd_q[i] + 4'd1;
					carry      = 1'b0;
				end
			end
			if (borrow) begin
				if (bcd_q[i] == '0) begin
					bcd_dec[i] = 4'd9;
				end else begin
					bcd_dec[i] = bcd_q[i] - 4'd1;
					borrow     = 1'b0;
				end
			end
		end
	end

	// up and down in one tick cancel: the up turn comes first, so zero never blocks it
	always_comb begin
		cnt_mid = cnt_q;
		bcd_mid = bcd_q;
		if (turn.up && !turn.down) begin
			cnt_mid = cnt_q + 14'd1;
			bcd_mid = bcd_inc;
		end else if (turn.down && !turn.up && !at_zero) begin
			cnt_mid = cnt_q - 14'd1;
			bcd_mid = bcd_dec;
		end
	end

	// buttons in order: store, preset low, clear, preset high
	always_comb begin
		target_nxt = target_q;
		if (item.store_button)       target_nxt = cnt_mid;
		if (item.preset_low_button)  target_nxt = preset_low;
		if (item.preset_high_button) target_nxt = preset_high;
		cnt_clr = item.clear_button ? '0 : cnt_mid;
	end

	always_comb begin
		priority if (cnt_clr < target_nxt) begin
			ind = tcd_pkg::IND_BELOW;
		end else if (cnt_clr == target_nxt) begin
			ind = tcd_pkg::IND_EQUAL;
		end else begin
			ind = tcd_pkg::IND_ABOVE;
		end
	end

	// wrap after the compare
	always_comb begin
		if (item.clear_button || cnt_clr > tcd_pkg::COUNT_LIMIT) begin
			cnt_nxt = '0;
			bcd_nxt = '0;
		end else begin
			cnt_nxt = cnt_clr;
			bcd_nxt = bcd_mid;
		end
	end

	always_comb begin
		result.indication      = ind;
		result.digit_position  = scan_q;
		result.segment_pattern = tcd_pkg::seg_decode(bcd_nxt[scan_q]);
		result.turn_count      = cnt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			bcd_q    <= '0;
			target_q <= '0;
			scan_q   <= '0;
		end else if (adv) begin
			cnt_q    <= cnt_nxt;
			bcd_q    <= bcd_nxt;
			target_q <= target_nxt;
			scan_q   <= scan_q + 2'd1;
		end
	end

endmodule

// ----- sv/turn_counter_with_target_display.sv -----
// ----------------------------------------------------------------------------
// turn_counter_with_target_display
// Counts turns from three position contacts, compares with a target and
// scans one decimal digit per item out as a seven-segment pattern.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  item     | item_valid / item_stall     | tcd_pkg::item_t, 7 bits
//  result   | result_valid / result_stall | tcd_pkg::result_t, 25 bits
//  config   | cfg_write, cfg_index        | cfg_data, 14 bits
//
// One item per cycle while no result stall holds the items back; a taken item
// goes through the input register, then the result register, where its result
// can be taken. The state update and the digit decode sit between the two
// registers. Reset clears the count, target, phase and scan position and
// loads the presets with 100 and 160.
// A stalled result holds the result register; the input register keeps
// taking items until it is full behind it.
// ----------------------------------------------------------------------------
module turn_counter_with_target_display (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  tcd_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output tcd_pkg::result_t            result,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [tcd_pkg::COUNT_W-1:0] cfg_data
);

	logic                        valid_s1;
	tcd_pkg::item_t              item_s1;
	logic                        adv;
	tcd_pkg::turn_t              turn;
	tcd_pkg::result_t            result_nxt;
	logic [tcd_pkg::COUNT_W-1:0] preset_low_q, preset_high_q;

	// advance the input item whenever the result register is free or draining
	assign adv        = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_low_q  <= tcd_pkg::PRESET_LOW_INIT;
			preset_high_q <= tcd_pkg::PRESET_HIGH_INIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tcd_pkg::CFG_PRESET_LOW:  preset_low_q  <= cfg_data;
				tcd_pkg::CFG_PRESET_HIGH: preset_high_q <= cfg_data;
				default:                  preset_low_q  <= preset_low_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	tcd_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.turn   (turn)
	);

	tcd_count u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item        (item_s1),
		.turn        (turn),
		.preset_low  (preset_low_q),
		.preset_high (preset_high_q),
		.result      (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= result_nxt;
		end
	end

`ifndef SYNTH
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.turn_count <= tcd_pkg::COUNT_LIMIT)
		else $error("turn count above limit");

	a_digit_not_blank: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.segment_pattern != '0)
		else $error("scanned digit decoded blank");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid && result_stall)
		else $error("item stalled with room in the pipeline");

	a_scan_advances: assert property (@(posedge clk) disable iff (!arst_n)
		adv && $past(adv) && $past(arst_n) |=>
			result.digit_position == $past(result.digit_position) + 2'd1)
		else $error("digit scan skipped a position");
`endif

endmodule

// ----- dv/tcd_result_checker.sv -----
// ----------------------------------------------------------------------------
// tcd_result_checker
// Watches the item, result and config channels of the turn counter. Keeps its
// own copy of the phase, count, target, scan position and presets, predicts
// one result per accepted item and compares every accepted result, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tcd_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  tcd_pkg::item_t              item,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  tcd_pkg::result_t            result,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [tcd_pkg::COUNT_W-1:0] cfg_data,
	output int unsigned                 errors,
	output int unsigned                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// index = digit value
	localparam logic [9:0][tcd_pkg::SEG_W-1:0] SEG_GLYPH = {
		7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_FIRST        = 3'd1,
		PH_FIRST_SECOND = 3'd2,
		PH_THIRD        = 3'd4,
		PH_THIRD_SECOND = 3'd5
	} phase_t;

	phase_t                      phase_q;
	logic [tcd_pkg::COUNT_W-1:0] count_q;
	logic [tcd_pkg::COUNT_W-1:0] target_q;
	logic [tcd_pkg::POS_W-1:0]   scan_q;
	logic [tcd_pkg::COUNT_W-1:0] preset_lo_q;
	logic [tcd_pkg::COUNT_W-1:0] preset_hi_q;
	tcd_pkg::result_t            predicted_results [$];
	tcd_pkg::result_t            oldest;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// One polling tick: phase rules in order, then buttons, compare, wrap, scan.
	function automatic tcd_pkg::result_t apply_tick(input tcd_pkg::item_t it);
		phase_t                      ph;
		logic [tcd_pkg::COUNT_W-1:0] cnt;
		int unsigned                 value;
		int unsigned                 digit;
		tcd_pkg::result_t            r;
		ph  = phase_q;
		cnt = count_q;

		if (ph == PH_IDLE && it.sensor_first) ph = PH_FIRST;
		if (ph == PH_FIRST && it.sensor_third) ph = PH_THIRD;
		if (ph == PH_FIRST && it.sensor_second) ph = PH_FIRST_SECOND;
		if (ph == PH_FIRST_SECOND && it.sensor_third) begin
			ph  = PH_FIRST;
			cnt = cnt + 1'b1;
		end
		if (ph == PH_FIRST_SECOND && it.sensor_first) ph = PH_FIRST;
		if (ph == PH_IDLE && it.sensor_third) ph = PH_THIRD;
		if (ph == PH_THIRD && it.sensor_first) ph = PH_FIRST;
		if (ph == PH_FIRST && it.sensor_third) ph = PH_THIRD;
		if (ph == PH_THIRD && it.sensor_second) ph = PH_THIRD_SECOND;
		if (ph == PH_THIRD_SECOND && it.sensor_first) begin
			ph = PH_FIRST;
			// hold at zero
			if (cnt != '0)
				cnt = cnt - 1'b1;
		end
		if (ph == PH_THIRD_SECOND && it.sensor_third) ph = PH_THIRD;

		if (it.store_button) target_q = cnt;
		if (it.preset_low_button) target_q = preset_lo_q;
		if (it.clear_button) cnt = '0;
		if (it.preset_high_button) target_q = preset_hi_q;

		if (cnt < target_q)
			r.indication = tcd_pkg::IND_BELOW;
		else if (cnt == target_q)
			r.indication = tcd_pkg::IND_EQUAL;
		else
			r.indication = tcd_pkg::IND_ABOVE;

		// wrap only after the compare
		if (cnt > tcd_pkg::COUNT_LIMIT)
			cnt = '0;

		value = 32'(cnt);
		case (scan_q)
			2'd0:    digit = value % 10;
			2'd1:    digit = (value / 10) % 10;
			2'd2:    digit = (value / 100) % 10;
			default: digit = value / 1000;
		endcase

		r.digit_position  = scan_q;
		r.segment_pattern = SEG_GLYPH[digit];
		r.turn_count      = cnt;

		phase_q = ph;
		count_q = cnt;
		scan_q  = scan_q + 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     = PH_IDLE;
			count_q     = '0;
			target_q    = '0;
			scan_q      = '0;
			preset_lo_q = tcd_pkg::PRESET_LOW_INIT;
			preset_hi_q = tcd_pkg::PRESET_HIGH_INIT;
			predicted_results.delete();
			pending     = 0;
			errors      = 0;
		end else begin
			// check first: a result never belongs to an item taken at the same edge
			if (result_valid && !result_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("result with no item outstanding, turn_count",
						result.turn_count, 0);
				end else begin
					oldest = predicted_results.pop_front();
					if (result.indication !== oldest.indication)
						report_mismatch("indication", result.indication, oldest.indication);
					if (result.digit_position !== oldest.digit_position)
						report_mismatch("digit_position", result.digit_position,
							oldest.digit_position);
					if (result.segment_pattern !== oldest.segment_pattern)
						report_mismatch("segment_pattern", result.segment_pattern,
							oldest.segment_pattern);
					if (result.turn_count !== oldest.turn_count)
						report_mismatch("turn_count", result.turn_count, oldest.turn_count);
				end
			end
			if (cfg_write) begin
				if (cfg_index == tcd_pkg::CFG_PRESET_LOW)
					preset_lo_q = cfg_data;
				else
					preset_hi_q = cfg_data;
			end
			if (item_valid && !item_stall)
				predicted_results.push_back(apply_tick(item));
			pending = predicted_results.size();
		end
	end

endmodule

// ----- dv/tb_turn_counter_with_target_display.sv -----
// ----------------------------------------------------------------------------
// tb_turn_counter_with_target_display
// Drives contact and button items into the turn counter with random gaps and
// result back-pressure, rewrites the presets between phases and ends with a
// run of items that has no idling. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_turn_counter_with_target_display;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned LONG_HOLD_AT   = 400;
	localparam int unsigned RANDOM_ITEMS   = 600;
	localparam int unsigned STEADY_ITEMS   = 80;
	localparam int unsigned END_LATENCY    = 4;

	// contacts {first, second, third}
	localparam logic [2:0] C_NONE   = 3'b000;
	localparam logic [2:0] C_FIRST  = 3'b100;
	localparam logic [2:0] C_SECOND = 3'b010;
	localparam logic [2:0] C_THIRD  = 3'b001;
	// buttons {store, preset low, clear, preset high}
	localparam logic [3:0] B_NONE  = 4'b0000;
	localparam logic [3:0] B_STORE = 4'b1000;
	localparam logic [3:0] B_PLOW  = 4'b0100;
	localparam logic [3:0] B_CLEAR = 4'b0010;
	localparam logic [3:0] B_PHIGH = 4'b0001;
	localparam logic [3:0] B_ALL   = B_STORE | B_PLOW | B_CLEAR | B_PHIGH;
	localparam logic [2:0] C_ALL   = C_FIRST | C_SECOND | C_THIRD;

	localparam logic [tcd_pkg::COUNT_W-1:0] REG_MAX = {tcd_pkg::COUNT_W{1'b1}};

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        item_valid   = 1'b0;
	tcd_pkg::item_t              item         = '0;
	logic                        result_stall = 1'b0;
	logic                        cfg_write    = 1'b0;
	logic                        cfg_index    = tcd_pkg::CFG_PRESET_LOW;
	logic [tcd_pkg::COUNT_W-1:0] cfg_data     = '0;
	logic                        item_stall;
	logic                        result_valid;
	tcd_pkg::result_t            result;

	int unsigned errors;
	int unsigned pending;
	int unsigned quiet  = 0;
	bit          steady = 1'b0;

	always #10 clk = ~clk;

	turn_counter_with_target_display dut (
		.clk, .arst_n,
		.item_valid, .item_stall, .item,
		.result_valid, .result_stall, .result,
		.cfg_write, .cfg_index, .cfg_data
	);

	tcd_result_checker result_check (
		.clk, .arst_n,
		.item_valid, .item_stall, .item,
		.result_valid, .result_stall, .result,
		.cfg_write, .cfg_index, .cfg_data,
		.errors, .pending
	);

	// mostly zero or short, now and then long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic tcd_pkg::item_t touch(input logic [2:0] contacts,
			input logic [3:0] buttons);
		return tcd_pkg::item_t'({contacts, buttons});
	endfunction

	// keep clear rare so the count gets somewhere
	function automatic logic [3:0] pick_buttons();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6) return 4'($urandom_range(0, 15)) & ~B_CLEAR;
		if (r < 7) return 4'($urandom_range(0, 15));
		return B_NONE;
	endfunction

	// Called at a rising edge; returns at the edge that takes the item.
	task automatic send_item(input tcd_pkg::item_t it);
		int unsigned gap;
		gap = steady ? 0 : gap_len();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
	endtask

	// Drain everything outstanding, then write both presets.
	task automatic set_presets(input logic [tcd_pkg::COUNT_W-1:0] lo,
			input logic [tcd_pkg::COUNT_W-1:0] hi);
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= tcd_pkg::CFG_PRESET_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= tcd_pkg::CFG_PRESET_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Mostly clean up and down turns, some broken sequences and noise.
	task automatic run_turns(input int unsigned n);
		int unsigned sent;
		int unsigned r;
		int unsigned len;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_item(touch(C_FIRST, pick_buttons()));
				send_item(touch(C_SECOND, pick_buttons()));
				send_item(touch(C_THIRD, pick_buttons()));
				sent += 3;
			end else if (r < 85) begin
				send_item(touch(C_THIRD, pick_buttons()));
				send_item(touch(C_SECOND, pick_buttons()));
				send_item(touch(C_FIRST, pick_buttons()));
				sent += 3;
			end else if (r < 93) begin
				len = $urandom_range(1, 3);
				repeat (len)
					send_item(touch(3'(1 << $urandom_range(0, 2)), pick_buttons()));
				sent += len;
			end else begin
				send_item(tcd_pkg::item_t'(7'($urandom_range(0, 127))));
				sent++;
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold-off so the block fills up.
	initial begin : result_sink
		int unsigned hold;
		int unsigned taken;
		bit          long_done;
		hold      = 0;
		taken     = 0;
		long_done = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				taken++;
			if (hold == 0) begin
				if (!long_done && taken >= LONG_HOLD_AT) begin
					hold      = LONG_HOLD;
					long_done = 1'b1;
				end else if (!steady && $urandom_range(0, 3) == 0) begin
					hold = gap_len();
				end
			end
			if (hold != 0) begin
				result_stall <= 1'b1;
				hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// down turn at zero holds the count
		send_item(touch(C_NONE, B_NONE));
		send_item(touch(C_THIRD, B_NONE));
		send_item(touch(C_SECOND, B_NONE));
		send_item(touch(C_FIRST, B_NONE));
		// two up turns, store the count
		send_item(touch(C_SECOND, B_NONE));
		send_item(touch(C_THIRD, B_NONE));
		send_item(touch(C_FIRST, B_NONE));
		send_item(touch(C_SECOND, B_NONE));
		send_item(touch(C_THIRD, B_STORE));
		send_item(touch(C_SECOND, B_NONE));
		send_item(touch(C_FIRST, B_NONE));
		// up and down in one tick
		send_item(touch(C_SECOND, B_NONE));
		send_item(touch(C_ALL, B_NONE));
		send_item(touch(C_NONE, B_PLOW));
		send_item(touch(C_NONE, B_PHIGH));
		// several buttons: the later target load wins
		send_item(touch(C_NONE, B_STORE | B_PLOW));
		send_item(touch(C_NONE, B_ALL));
		send_item(touch(C_ALL, B_ALL));

		set_presets('0, REG_MAX);
		send_item(touch(C_NONE, B_PLOW));
		send_item(touch(C_NONE, B_PHIGH));
		send_item(touch(C_FIRST | C_THIRD, B_CLEAR | B_PLOW));

		set_presets(tcd_pkg::COUNT_W'($urandom_range(0, 40)),
			tcd_pkg::COUNT_W'($urandom_range(0, 400)));
		run_turns(RANDOM_ITEMS);
		set_presets(tcd_pkg::COUNT_LIMIT, '0);
		run_turns(RANDOM_ITEMS);
		set_presets(tcd_pkg::COUNT_W'($urandom_range(0, 16383)),
			tcd_pkg::COUNT_W'($urandom_range(0, 60)));
		run_turns(RANDOM_ITEMS);

		// presets at the top of the range, then items back to back with no idling
		set_presets(tcd_pkg::COUNT_LIMIT, tcd_pkg::COUNT_LIMIT + 1'b1);
		steady = 1'b1;
		run_turns(STEADY_ITEMS);
		steady = 1'b0;

		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (END_LATENCY) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tcd_pkg.sv
sv/tcd_phase.sv
sv/tcd_count.sv
sv/turn_counter_with_target_display.sv
dv/tcd_result_checker.sv
dv/tb_turn_counter_with_target_display.sv
